>>> sv/tode_pkg.sv
`default_nettype none

package tode_pkg;

  // Table size
  localparam int unsigned ENTRIES_DEF = 64;

  // Field widths
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned LIGHT_W = 8;
  localparam int unsigned DAY_W   = 4;
  localparam int unsigned MIN_W   = 11;
  localparam int unsigned OFS_W   = 7;
  localparam int unsigned ACT_W   = 2;
  localparam int unsigned DUE_W   = MIN_W + 2;

  // Command codes
  localparam logic [MODE_W-1:0] MODE_ADD_ON    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ADD_OFF   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RANDOMIZE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REMOVE    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TICK      = 3'd4;

  // Day codes
  localparam logic [DAY_W-1:0] DAY_SUN     = 4'd0;
  localparam logic [DAY_W-1:0] DAY_MON     = 4'd1;
  localparam logic [DAY_W-1:0] DAY_FRI     = 4'd5;
  localparam logic [DAY_W-1:0] DAY_SAT     = 4'd6;
  localparam logic [DAY_W-1:0] DAY_EVERY   = 4'd7;
  localparam logic [DAY_W-1:0] DAY_WEEKDAY = 4'd8;
  localparam logic [DAY_W-1:0] DAY_WEEKEND = 4'd9;

  // Result codes
  localparam logic [ACT_W-1:0] ACT_NONE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ON   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_OFF  = 2'd2;
  localparam logic             STAT_OK   = 1'b0;
  localparam logic             STAT_FULL = 1'b1;

  // One table entry as stored in the memory
  typedef struct packed {
    logic [LIGHT_W-1:0] light;
    logic [DAY_W-1:0]   day;
    logic [MIN_W-1:0]   minute;
    logic               turns_on;
    logic               random;
    logic [OFS_W-1:0]   offset;
  } entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic rd_en;
    logic ev_en;
    logic fin_en;
  } tode_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic ev_stall;
    logic fin_done;
  } tode_stat_t;

  // Day rule of an entry against today
  function automatic logic day_match(input logic [DAY_W-1:0] rule,
                                     input logic [DAY_W-1:0] today);
    day_match = (rule == DAY_EVERY) || (rule == today) ||
                ((rule == DAY_WEEKEND) && ((today == DAY_SUN) || (today == DAY_SAT))) ||
                ((rule == DAY_WEEKDAY) && (today >= DAY_MON) && (today <= DAY_FRI));
  endfunction

endpackage

`default_nettype wire

>>> sv/time_of_day_event_table.sv
// Time-of-day event table: a table of ENTRIES scheduled light on/off events.
// Input channel (in_*): one transaction is a command. in_mode selects add
// turn-on, add turn-off, randomize, remove or tick. Table commands give one
// result with light 0, action none and last set; out_status flags an add
// dropped on a full table. A tick gives one result per firing entry in table
// order with out_last on the final one, or a single null result.
// Each transaction walks every entry once through a table memory with one
// write and one registered read per cycle, then posts the closing result;
// a new transaction is taken only after that closing result has been posted.
// Results leave through a one-deep output register; while the receiver
// stalls, a second firing holds the scan until the register drains.
// Reset (rst_n low at a clock edge) empties the table at once through
// per-entry valid flags and drops any transaction in flight.
`default_nettype none

module time_of_day_event_table #(
  parameter int unsigned ENTRIES = tode_pkg::ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [tode_pkg::MODE_W-1:0]        in_mode,
  input  logic [tode_pkg::LIGHT_W-1:0]       in_light_id,
  input  logic [tode_pkg::DAY_W-1:0]         in_day_code,
  input  logic [tode_pkg::MIN_W-1:0]         in_minute,
  input  logic signed [tode_pkg::OFS_W-1:0]  in_random_offset,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [tode_pkg::LIGHT_W-1:0]       out_light_id_res,
  output logic [tode_pkg::ACT_W-1:0]         out_action,
  output logic                               out_status,
  output logic                               out_last
);
  import tode_pkg::*;

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  tode_cmd_t     cmd;
  tode_stat_t    stat;
  logic [IW-1:0] rd_idx;
  logic [IW-1:0] ev_idx;

  // Sequencer
  tode_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd),
    .rd_idx   (rd_idx),
    .ev_idx   (ev_idx)
  );

  // Table, match logic and output register
  tode_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .rd_idx           (rd_idx),
    .ev_idx           (ev_idx),
    .stat             (stat),
    .in_mode          (in_mode),
    .in_light_id      (in_light_id),
    .in_day_code      (in_day_code),
    .in_minute        (in_minute),
    .in_random_offset (in_random_offset),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_light_id_res (out_light_id_res),
    .out_action       (out_action),
    .out_status       (out_status),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire

>>> sv/tode_ctrl.sv
`default_nettype none

module tode_ctrl #(
  parameter int unsigned ENTRIES = tode_pkg::ENTRIES_DEF,
  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int unsigned CW = $clog2(ENTRIES + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  tode_pkg::tode_stat_t   stat,
  output tode_pkg::tode_cmd_t    cmd,
  output logic [IW-1:0]          rd_idx,
  output logic [IW-1:0]          ev_idx
);
  import tode_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  localparam logic [CW-1:0] CNT_END = CW'(ENTRIES);

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] rd_cnt_r, rd_cnt_nxt;
  logic          ev_valid_r, ev_valid_nxt;
  logic [IW-1:0] ev_idx_r, ev_idx_nxt;

  // Sequencer: read stage runs one entry ahead of the evaluate stage
  always_comb begin
    state_nxt    = state_r;
    rd_cnt_nxt   = rd_cnt_r;
    ev_valid_nxt = ev_valid_r;
    ev_idx_nxt   = ev_idx_r;
    cmd          = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load     = 1'b1;
          rd_cnt_nxt   = '0;
          ev_valid_nxt = 1'b0;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        // hold everything while a firing waits for the output slot
        if (!(ev_valid_r && stat.ev_stall)) begin
          cmd.ev_en = ev_valid_r;
          if (rd_cnt_r != CNT_END) begin
            cmd.rd_en    = 1'b1;
            ev_valid_nxt = 1'b1;
            ev_idx_nxt   = rd_cnt_r[IW-1:0];
            rd_cnt_nxt   = rd_cnt_r + CW'(1);
          end else begin
            ev_valid_nxt = 1'b0;
            state_nxt    = S_FIN;
          end
        end
      end
      S_FIN: begin
        cmd.fin_en = 1'b1;
        if (stat.fin_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      rd_cnt_r   <= '0;
      ev_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rd_cnt_r   <= rd_cnt_nxt;
      ev_valid_r <= ev_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ev_idx_r <= ev_idx_nxt;
  end

  assign in_ready = (state_r == S_IDLE);
  assign rd_idx   = rd_cnt_r[IW-1:0];
  assign ev_idx   = ev_idx_r;

  // Checks
  a_idle_no_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !ev_valid_r)
    else $error("evaluate stage busy while idle");

  a_start_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> ((state_r == S_SCAN) && (rd_cnt_r == '0)))
    else $error("scan did not start at entry zero");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_cnt_r <= CNT_END)
    else $error("read counter beyond table");

endmodule

`default_nettype wire

>>> sv/tode_dp.sv
`default_nettype none

module tode_dp #(
  parameter int unsigned ENTRIES = tode_pkg::ENTRIES_DEF,
  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  tode_pkg::tode_cmd_t                   cmd,
  input  logic [IW-1:0]                         rd_idx,
  input  logic [IW-1:0]                         ev_idx,
  output tode_pkg::tode_stat_t                  stat,
  input  logic [tode_pkg::MODE_W-1:0]           in_mode,
  input  logic [tode_pkg::LIGHT_W-1:0]          in_light_id,
  input  logic [tode_pkg::DAY_W-1:0]            in_day_code,
  input  logic [tode_pkg::MIN_W-1:0]            in_minute,
  input  logic signed [tode_pkg::OFS_W-1:0]     in_random_offset,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [tode_pkg::LIGHT_W-1:0]          out_light_id_res,
  output logic [tode_pkg::ACT_W-1:0]            out_action,
  output logic                                  out_status,
  output logic                                  out_last
);
  import tode_pkg::*;

  // Table storage
  entry_t             mem [ENTRIES];
  entry_t             rdata_r;
  logic [ENTRIES-1:0] valid_r, valid_nxt;

  // Current transaction
  logic [MODE_W-1:0]  mode_r;
  logic [LIGHT_W-1:0] light_r;
  logic [DAY_W-1:0]   day_r;
  logic [MIN_W-1:0]   minute_r;
  logic [OFS_W-1:0]   roff_r;

  // Scan state and held firing
  logic               found_r, found_nxt;
  logic               pend_valid_r, pend_valid_nxt;
  logic [LIGHT_W-1:0] pend_light_r, pend_light_nxt;
  logic               pend_on_r, pend_on_nxt;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  logic [LIGHT_W-1:0] out_light_r, out_light_nxt;
  logic [ACT_W-1:0]   out_act_r, out_act_nxt;
  logic               out_stat_r, out_stat_nxt;
  logic               out_last_r, out_last_nxt;

  logic               ev_vbit;
  logic               is_add;
  logic               hit;
  logic               fire;
  logic               slot_free;
  logic [DUE_W-1:0]   due;
  logic               wr_en;
  entry_t             wr_data;
  logic               push;

  // Entry evaluation
  always_comb begin
    ev_vbit   = valid_r[ev_idx];
    is_add    = (mode_r == MODE_ADD_ON) || (mode_r == MODE_ADD_OFF);
    hit       = ev_vbit && (rdata_r.light == light_r) && (rdata_r.day == day_r) &&
                (rdata_r.minute == minute_r);
    due       = {2'b00, rdata_r.minute} +
                {{(DUE_W - OFS_W){rdata_r.offset[OFS_W-1]}}, rdata_r.offset};
    fire      = (mode_r == MODE_TICK) && ev_vbit && day_match(rdata_r.day, day_r) &&
                (due == {2'b00, minute_r});
    slot_free = !out_valid_r || out_ready;
    stat.ev_stall = fire && pend_valid_r && !slot_free;
    stat.fin_done = slot_free;
  end

  // Table update and result generation
  always_comb begin
    valid_nxt      = valid_r;
    found_nxt      = found_r;
    pend_valid_nxt = pend_valid_r;
    pend_light_nxt = pend_light_r;
    pend_on_nxt    = pend_on_r;
    wr_en          = 1'b0;
    wr_data        = rdata_r;
    push           = 1'b0;
    out_light_nxt  = out_light_r;
    out_act_nxt    = out_act_r;
    out_stat_nxt   = out_stat_r;
    out_last_nxt   = out_last_r;

    if (cmd.load) begin
      found_nxt      = 1'b0;
      pend_valid_nxt = 1'b0;
    end

    if (cmd.ev_en) begin
      unique case (mode_r) inside
        MODE_ADD_ON, MODE_ADD_OFF: begin
          if (!ev_vbit && !found_r) begin
            wr_en            = 1'b1;
            wr_data.light    = light_r;
            wr_data.day      = day_r;
            wr_data.minute   = minute_r;
            wr_data.turns_on = (mode_r == MODE_ADD_ON);
            wr_data.random   = 1'b0;
            wr_data.offset   = '0;
            valid_nxt[ev_idx] = 1'b1;
            found_nxt        = 1'b1;
          end
        end
        MODE_RANDOMIZE: begin
          if (hit) begin
            wr_en          = 1'b1;
            wr_data.random = 1'b1;
            wr_data.offset = roff_r;
          end
        end
        MODE_REMOVE: begin
          if (hit) begin
            valid_nxt[ev_idx] = 1'b0;
          end
        end
        MODE_TICK: begin
          if (fire) begin
            wr_en          = 1'b1;
            wr_data.offset = rdata_r.random ? roff_r : '0;
            // the previous firing is not the last one
            if (pend_valid_r) begin
              push          = 1'b1;
              out_light_nxt = pend_light_r;
              out_act_nxt   = pend_on_r ? ACT_ON : ACT_OFF;
              out_stat_nxt  = STAT_OK;
              out_last_nxt  = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_light_nxt = rdata_r.light;
            pend_on_nxt    = rdata_r.turns_on;
          end
        end
        default: begin
        end
      endcase
    end

    // Closing result of the transaction
    if (cmd.fin_en && slot_free) begin
      push         = 1'b1;
      out_last_nxt = 1'b1;
      if (pend_valid_r) begin
        out_light_nxt  = pend_light_r;
        out_act_nxt    = pend_on_r ? ACT_ON : ACT_OFF;
        out_stat_nxt   = STAT_OK;
        pend_valid_nxt = 1'b0;
      end else begin
        out_light_nxt = '0;
        out_act_nxt   = ACT_NONE;
        out_stat_nxt  = (is_add && !found_r) ? STAT_FULL : STAT_OK;
      end
    end

    if (push) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[ev_idx] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_idx];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      found_r      <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      valid_r      <= valid_nxt;
      found_r      <= found_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r   <= in_mode;
      light_r  <= in_light_id;
      day_r    <= in_day_code;
      minute_r <= in_minute;
      roff_r   <= in_random_offset;
    end
    pend_light_r <= pend_light_nxt;
    pend_on_r    <= pend_on_nxt;
    out_light_r  <= out_light_nxt;
    out_act_r    <= out_act_nxt;
    out_stat_r   <= out_stat_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_light_id_res = out_light_r;
  assign out_action       = out_act_r;
  assign out_status       = out_stat_r;
  assign out_last         = out_last_r;

  // Checks
  a_pend_tick: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> (mode_r == MODE_TICK))
    else $error("held firing outside a tick");

  a_found_add: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> ((mode_r == MODE_ADD_ON) || (mode_r == MODE_ADD_OFF)))
    else $error("free slot taken outside an add");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> slot_free)
    else $error("result overwrote a waiting result");

endmodule

`default_nettype wire

>>> bench/time_of_day_event_table_tb.sv
module time_of_day_event_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tode_pkg::*;

  localparam int ENTRIES     = int'(ENTRIES_DEF);
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_WAIT  = 3 * (ENTRIES + 3);

  // One result transaction as seen on the out_* port
  typedef struct packed {
    logic [LIGHT_W-1:0] light;
    logic [ACT_W-1:0]   action;
    logic               status;
    logic               last;
  } light_event_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [MODE_W-1:0]        in_mode = '0;
  logic [LIGHT_W-1:0]       in_light_id = '0;
  logic [DAY_W-1:0]         in_day_code = '0;
  logic [MIN_W-1:0]         in_minute = '0;
  logic signed [OFS_W-1:0]  in_random_offset = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [LIGHT_W-1:0]       out_light_id_res;
  logic [ACT_W-1:0]         out_action;
  logic                     out_status;
  logic                     out_last;

  // Shadow copy of the event table
  logic                     sched_valid [ENTRIES];
  logic [LIGHT_W-1:0]       sched_light [ENTRIES];
  logic [DAY_W-1:0]         sched_day [ENTRIES];
  logic [MIN_W-1:0]         sched_minute [ENTRIES];
  logic                     sched_turns_on [ENTRIES];
  logic                     sched_random [ENTRIES];
  logic signed [OFS_W-1:0]  sched_offset [ENTRIES];

  light_event_t             pending_events [$];
  light_event_t             got_event;
  logic [MIN_W-1:0]         minute_pool [3];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_cnt      = 0;
  int n_cmds        = 0;
  int n_ticks       = 0;
  int n_fired       = 0;
  int n_dropped     = 0;
  int n_checked     = 0;
  int stall_cnt     = 0;

  time_of_day_event_table u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_light_id      (in_light_id),
    .in_day_code      (in_day_code),
    .in_minute        (in_minute),
    .in_random_offset (in_random_offset),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_light_id_res (out_light_id_res),
    .out_action       (out_action),
    .out_status       (out_status),
    .out_last         (out_last)
  );

  always #5 clk = ~clk;

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      sched_valid[i] = 1'b0;
    end
  end

  // Receiver backpressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Result checker: compare each result transaction with the oldest pending event
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        $error("result with nothing pending: light %0d action %0d status %0d last %0d",
               out_light_id_res, out_action, out_status, out_last);
        fail_cnt++;
      end else begin
        got_event = pending_events.pop_front();
        n_checked++;
        if (out_light_id_res !== got_event.light) begin
          $error("light_id_res: expected %0d, got %0d", got_event.light, out_light_id_res);
          fail_cnt++;
        end
        if (out_action !== got_event.action) begin
          $error("action: expected %0d, got %0d", got_event.action, out_action);
          fail_cnt++;
        end
        if (out_status !== got_event.status) begin
          $error("status: expected %0d, got %0d", got_event.status, out_status);
          fail_cnt++;
        end
        if (out_last !== got_event.last) begin
          $error("last: expected %0d, got %0d", got_event.last, out_last);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog: too long without any transaction on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("time_of_day_event_table test failed");
        $finish;
      end
    end
  end

  function automatic logic day_rule_hits(input logic [DAY_W-1:0] rule,
                                         input logic [DAY_W-1:0] today);
    if (rule == DAY_EVERY || rule == today) return 1'b1;
    if (rule == DAY_WEEKEND && (today == DAY_SUN || today == DAY_SAT)) return 1'b1;
    if (rule == DAY_WEEKDAY && today >= DAY_MON && today <= DAY_FRI) return 1'b1;
    return 1'b0;
  endfunction

  function automatic light_event_t make_event(input logic [LIGHT_W-1:0] light,
                                              input logic [ACT_W-1:0] action,
                                              input logic status,
                                              input logic last);
    light_event_t ev;
    ev.light  = light;
    ev.action = action;
    ev.status = status;
    ev.last   = last;
    return ev;
  endfunction

  // Apply one command to the shadow table and queue the events it should produce
  task automatic schedule_apply(input logic [MODE_W-1:0] mode,
                                input logic [LIGHT_W-1:0] light,
                                input logic [DAY_W-1:0] day,
                                input logic [MIN_W-1:0] minute,
                                input logic signed [OFS_W-1:0] roff);
    int   slot;
    int   fired;
    int   due;
    logic null_res;
    slot     = -1;
    fired    = 0;
    null_res = 1'b1;
    n_cmds++;
    case (mode)
      MODE_ADD_ON, MODE_ADD_OFF: begin
        null_res = 1'b0;
        for (int i = 0; i < ENTRIES && slot < 0; i++) begin
          if (!sched_valid[i]) slot = i;
        end
        if (slot >= 0) begin
          sched_valid[slot]    = 1'b1;
          sched_light[slot]    = light;
          sched_day[slot]      = day;
          sched_minute[slot]   = minute;
          sched_turns_on[slot] = (mode == MODE_ADD_ON);
          sched_random[slot]   = 1'b0;
          sched_offset[slot]   = '0;
          pending_events.push_back(make_event('0, ACT_NONE, STAT_OK, 1'b1));
        end else begin
          n_dropped++;
          pending_events.push_back(make_event('0, ACT_NONE, STAT_FULL, 1'b1));
        end
      end
      MODE_RANDOMIZE, MODE_REMOVE: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (sched_valid[i] && sched_light[i] == light && sched_day[i] == day &&
              sched_minute[i] == minute) begin
            if (mode == MODE_REMOVE) begin
              sched_valid[i] = 1'b0;
            end else begin
              sched_random[i] = 1'b1;
              sched_offset[i] = roff;
            end
          end
        end
      end
      MODE_TICK: begin
        n_ticks++;
        for (int i = 0; i < ENTRIES; i++) begin
          if (sched_valid[i] && day_rule_hits(sched_day[i], day)) begin
            // exact signed sum, no wrap around midnight
            due = int'(sched_minute[i]) + int'(sched_offset[i]);
            if (due == int'(minute)) begin
              pending_events.push_back(make_event(sched_light[i],
                sched_turns_on[i] ? ACT_ON : ACT_OFF, STAT_OK, 1'b0));
              fired++;
              sched_offset[i] = sched_random[i] ? roff : '0;
            end
          end
        end
        if (fired > 0) begin
          null_res = 1'b0;
          n_fired += fired;
          pending_events[pending_events.size()-1].last = 1'b1;
        end
      end
      default: ;
    endcase
    if (null_res) begin
      pending_events.push_back(make_event('0, ACT_NONE, STAT_OK, 1'b1));
    end
  endtask

  // Send one command transaction; valid stays high until accepted
  task automatic send_cmd(input logic [MODE_W-1:0] mode,
                          input logic [LIGHT_W-1:0] light,
                          input logic [DAY_W-1:0] day,
                          input logic [MIN_W-1:0] minute,
                          input logic signed [OFS_W-1:0] roff);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_mode          <= mode;
    in_light_id      <= light;
    in_day_code      <= day;
    in_minute        <= minute;
    in_random_offset <= roff;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    schedule_apply(mode, light, day, minute, roff);
  endtask

  // Hold off new commands until every pending event has come out
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
  endtask

  // Day rules, odd day codes, field extremes, firing with zero offset
  task automatic test_add_and_fire();
    send_cmd(MODE_ADD_ON, 8'd255, DAY_EVERY, 11'd0, 7'sd0);
    send_cmd(MODE_ADD_OFF, 8'd0, DAY_WEEKDAY, 11'd1439, 7'sd63);
    send_cmd(MODE_ADD_ON, 8'h5a, DAY_WEEKEND, 11'd1439, -7'sd64);
    send_cmd(MODE_ADD_ON, 8'ha5, 4'd3, 11'd1439, 7'sd0);
    send_cmd(MODE_ADD_OFF, 8'd1, 4'd12, 11'd1439, 7'sd0);
    send_cmd(MODE_TICK, 8'd255, 4'd3, 11'd1439, 7'sd5);
    send_cmd(MODE_TICK, 8'd0, DAY_SAT, 11'd1439, 7'sd0);
    send_cmd(MODE_TICK, 8'd0, 4'd12, 11'd1439, 7'sd0);
    send_cmd(MODE_TICK, 8'd0, DAY_SUN, 11'd0, 7'sd0);
    send_cmd(MODE_TICK, 8'd0, DAY_SUN, 11'd5, 7'sd0);
  endtask

  // Offsets pushing the due minute below zero and past midnight, re-randomize on firing, removals
  task automatic test_randomize_remove();
    wait_results_drained();
    send_cmd(MODE_RANDOMIZE, 8'd255, DAY_EVERY, 11'd0, -7'sd64);
    send_cmd(MODE_TICK, 8'd0, DAY_MON, 11'd0, 7'sd0);
    send_cmd(MODE_RANDOMIZE, 8'd0, DAY_WEEKDAY, 11'd1439, 7'sd63);
    send_cmd(MODE_TICK, 8'd0, 4'd2, 11'd1502, -7'sd1);
    send_cmd(MODE_TICK, 8'd0, 4'd2, 11'd1438, 7'sd0);
    send_cmd(MODE_RANDOMIZE, 8'd0, DAY_WEEKDAY, 11'd1438, 7'sd9);
    send_cmd(MODE_REMOVE, 8'h5a, DAY_WEEKEND, 11'd1439, 7'sd0);
    send_cmd(MODE_TICK, 8'd0, DAY_SUN, 11'd1439, 7'sd0);
    send_cmd(MODE_REMOVE, 8'd255, DAY_EVERY, 11'd0, 7'sd0);
  endtask

  // Unused mode codes and an all-ones tick
  task automatic test_unused_modes();
    send_cmd(3'd5, 8'hff, 4'hf, 11'h7ff, -7'sd1);
    send_cmd(3'd6, 8'h00, DAY_EVERY, 11'd1439, 7'sd0);
    send_cmd(3'd7, 8'd1, 4'd12, 11'd1439, 7'sd63);
    send_cmd(MODE_TICK, 8'hff, 4'hf, 11'h7ff, -7'sd1);
  endtask

  function automatic int pick_entry();
    int idx [$];
    for (int i = 0; i < ENTRIES; i++) begin
      if (sched_valid[i]) idx.push_back(i);
    end
    if (idx.size() == 0) return -1;
    return idx[$urandom_range(0, idx.size() - 1)];
  endfunction

  function automatic logic [DAY_W-1:0] today_for_rule(input logic [DAY_W-1:0] rule);
    case (rule)
      DAY_EVERY:   return DAY_W'($urandom_range(0, 6));
      DAY_WEEKDAY: return DAY_W'($urandom_range(DAY_MON, DAY_FRI));
      DAY_WEEKEND: return $urandom_range(0, 1) ? DAY_SUN : DAY_SAT;
      default:     return rule;
    endcase
  endfunction

  function automatic logic [MIN_W-1:0] random_minute();
    case ($urandom_range(0, 9))
      6:       return 11'd0;
      7:       return 11'd1439;
      8:       return MIN_W'($urandom_range(1440, 2047));
      9:       return MIN_W'($urandom_range(0, 1439));
      default: return minute_pool[$urandom_range(0, 2)];
    endcase
  endfunction

  // Random traffic: keys mostly reuse table contents so matches and firings are common
  task automatic test_random_traffic(input int n_items, input int add_pct);
    logic [MODE_W-1:0]       mode;
    logic [LIGHT_W-1:0]      light;
    logic [DAY_W-1:0]        day;
    logic [MIN_W-1:0]        minute;
    logic signed [OFS_W-1:0] roff;
    int                      pick;
    int                      sel;
    int                      due;
    for (int p = 0; p < 3; p++) begin
      minute_pool[p] = MIN_W'($urandom_range(0, 1439));
    end
    for (int k = 0; k < n_items; k++) begin
      light  = LIGHT_W'($urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 255));
      day    = DAY_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) :
                                                   $urandom_range(0, 9));
      minute = random_minute();
      roff   = OFS_W'($urandom_range(0, 127));
      pick   = pick_entry();
      sel    = $urandom_range(0, 99);
      if (sel < add_pct) begin
        mode = $urandom_range(0, 1) ? MODE_ADD_ON : MODE_ADD_OFF;
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
          mode = MODE_TICK;
          if (pick >= 0 && $urandom_range(0, 99) < 80) begin
            day = today_for_rule(sched_day[pick]);
            due = int'(sched_minute[pick]) + int'(sched_offset[pick]);
            if (due >= 0 && due <= 2047) minute = MIN_W'(due);
          end
        end else if (sel < 88) begin
          mode = (sel < 65) ? MODE_RANDOMIZE : MODE_REMOVE;
          if (pick >= 0 && $urandom_range(0, 99) < 85) begin
            light  = sched_light[pick];
            day    = sched_day[pick];
            minute = sched_minute[pick];
          end
        end else begin
          mode = MODE_W'($urandom_range(5, 7));
        end
      end
      send_cmd(mode, light, day, minute, roff);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 29;
    recv_idle_pct = 78;
    test_add_and_fire();
    test_randomize_remove();
    test_unused_modes();
    test_random_traffic(100, 40);
    wait_results_drained();

    send_idle_pct = 78;
    recv_idle_pct = 29;
    test_random_traffic(100, 70);
    wait_results_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(100, 20);
    wait_results_drained();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Ran %0d commands including %0d ticks: %0d entries fired, %0d adds hit a full table.",
             n_cmds, n_ticks, n_fired, n_dropped);
    $display("Checked %0d result transactions under three sender/receiver stall mixes.",
             n_checked);
    if (fail_cnt == 0) begin
      $display("time_of_day_event_table test passed");
    end else begin
      $display("time_of_day_event_table test failed");
    end
    $finish;
  end

endmodule
